// ===== design/mue_pkg.sv =====
// Shared types, codes and the modified base64 character table for the modified UTF-7 encoder.
`timescale 1ns / 1ps

package mue_pkg;

   // Run phase: plain text, or inside a run with 0, 8 or 16 bits of a group used
   localparam logic [1:0] PHASE_PLAIN = 2'd0;
   localparam logic [1:0] PHASE_G0    = 2'd1;
   localparam logic [1:0] PHASE_G1    = 2'd2;
   localparam logic [1:0] PHASE_G2    = 2'd3;

   localparam logic [7:0] AMP_CHAR  = 8'h26;
   localparam logic [7:0] DASH_CHAR = 8'h2D;
   localparam logic [7:0] PLAIN_LO  = 8'h20;
   localparam logic [7:0] PLAIN_HI  = 8'h7E;

   localparam int QUEUE_DEPTH = 2;

   // Up to four characters produced by one input byte
   typedef struct packed {
      logic [3:0][6:0] chars;
      logic [1:0]      last_idx;
      logic            is_last;
   } bundle_type;

   function automatic logic [6:0] sextet_char(input logic [5:0] v);
      logic [6:0] c;
      if (v < 6'd26) begin
         c = 7'h41 + {1'b0, v};
      end else if (v < 6'd52) begin
         c = 7'h61 + {1'b0, v - 6'd26};
      end else if (v < 6'd62) begin
         c = 7'h30 + {1'b0, v - 6'd52};
      end else if (v == 6'd62) begin
         c = 7'h2B;
      end else begin
         c = 7'h2C;
      end
      return c;
   endfunction

endpackage

// ===== design/mue_front.sv =====
// Front end: classifies each byte, tracks the run state and builds its character bundle.
`timescale 1ns / 1ps

module mue_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic                is_last,
   output mue_pkg::bundle_type bundle
);

   logic [1:0] phase_ff, phase_in;
   logic [5:0] carry_ff, carry_in;

   always_comb begin
      logic [2:0]      n;
      logic [3:0][6:0] ch;
      logic [1:0]      ph;
      logic [5:0]      cy;
      logic            plain;
      n     = 3'd0;
      ch    = '0;
      ph    = phase_ff;
      cy    = carry_ff;
      plain = (in_byte >= mue_pkg::PLAIN_LO) && (in_byte <= mue_pkg::PLAIN_HI);

      if (plain) begin
         // close an open run before the plain byte
         if (ph != mue_pkg::PHASE_PLAIN) begin
            if (ph != mue_pkg::PHASE_G0) begin
               ch[n[1:0]] = mue_pkg::sextet_char(cy);
               n = n + 3'd1;
            end
            ch[n[1:0]] = mue_pkg::DASH_CHAR[6:0];
            n  = n + 3'd1;
            ph = mue_pkg::PHASE_PLAIN;
            cy = '0;
         end
         ch[n[1:0]] = in_byte[6:0];
         n = n + 3'd1;
         if (in_byte == mue_pkg::AMP_CHAR) begin
            ch[n[1:0]] = mue_pkg::DASH_CHAR[6:0];
            n = n + 3'd1;
         end
      end else begin
         if (ph == mue_pkg::PHASE_PLAIN) begin
            ch[n[1:0]] = mue_pkg::AMP_CHAR[6:0];
            n  = n + 3'd1;
            ph = mue_pkg::PHASE_G0;
            cy = '0;
         end
         case (ph)
            mue_pkg::PHASE_G0: begin
               ch[n[1:0]] = mue_pkg::sextet_char(in_byte[7:2]);
               n  = n + 3'd1;
               cy = {in_byte[1:0], 4'b0000};
               ph = mue_pkg::PHASE_G1;
            end
            mue_pkg::PHASE_G1: begin
               ch[n[1:0]] = mue_pkg::sextet_char(cy | {2'b00, in_byte[7:4]});
               n  = n + 3'd1;
               cy = {in_byte[3:0], 2'b00};
               ph = mue_pkg::PHASE_G2;
            end
            default: begin
               ch[n[1:0]] = mue_pkg::sextet_char(cy | {4'b0000, in_byte[7:6]});
               n = n + 3'd1;
               ch[n[1:0]] = mue_pkg::sextet_char(in_byte[5:0]);
               n  = n + 3'd1;
               cy = '0;
               ph = mue_pkg::PHASE_G0;
            end
         endcase
      end

      // end of string closes any open run
      if (is_last && (ph != mue_pkg::PHASE_PLAIN)) begin
         if (ph != mue_pkg::PHASE_G0) begin
            ch[n[1:0]] = mue_pkg::sextet_char(cy);
            n = n + 3'd1;
         end
         ch[n[1:0]] = mue_pkg::DASH_CHAR[6:0];
         n  = n + 3'd1;
         ph = mue_pkg::PHASE_PLAIN;
         cy = '0;
      end

      bundle.chars    = ch;
      bundle.last_idx = 2'(n - 3'd1);
      bundle.is_last  = is_last;
      phase_in        = ph;
      carry_in        = cy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mue_pkg::PHASE_PLAIN;
         carry_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

// ===== design/mue_queue.sv =====
// Short bundle queue between the front end and the output serializer.
`timescale 1ns / 1ps

module mue_queue #(
   parameter int Depth = mue_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mue_pkg::bundle_type push_data,
   output logic                full,
   input  logic                pop,
   output mue_pkg::bundle_type head,
   output logic                empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   mue_pkg::bundle_type store [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic            do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = store[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== design/mue_back.sv =====
// Back end: walks the head bundle one character per cycle, while the output is not stalled, into the output register.
`timescale 1ns / 1ps

module mue_back (
   input  logic                clock,
   input  logic                reset,
   input  mue_pkg::bundle_type head,
   input  logic                head_valid,
   output logic                head_pop,
   input  logic                pop,
   output logic                empty,
   output logic [6:0]          out_char,
   output logic                last_of_run,
   output logic                end_of_string
);

   logic [1:0] idx_ff;
   logic       valid_ff;
   logic [6:0] char_ff;
   logic       lor_ff, eos_ff;
   logic       advance, load, final_char;

   assign advance    = !valid_ff || pop;
   assign load       = advance && head_valid;
   assign final_char = (idx_ff == head.last_idx);
   assign head_pop   = load && final_char;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (advance) begin
            valid_ff <= head_valid;
         end
         if (load) begin
            idx_ff <= final_char ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= head.chars[idx_ff];
         lor_ff  <= final_char;
         eos_ff  <= final_char && head.is_last;
      end
   end

   assign empty         = !valid_ff;
   assign out_char      = char_ff;
   assign last_of_run   = lor_ff;
   assign end_of_string = eos_ff;

endmodule

// ===== design/modified_utf7_encoder.sv =====
// Top level of the modified UTF-7 encoder: front end, bundle queue and serializer.
//
//   channel | direction | handshake          | word
//   req     | in        | req_push/req_full  | req_in_byte, req_is_last
//   rsp     | out       | rsp_pop/rsp_empty  | rsp_out_char, rsp_last_of_run,
//           |           |                    | rsp_end_of_string
//
// One input byte is taken per cycle while the queue has room; it yields 1 to 4
// characters, and the serializer drives one character per cycle while the output
// is not stalled.
// An accepted byte's bundle is queued, then its first character is registered.
// Synchronous reset returns to plain text and empties the queue and output.
// An output stall backs up into the queue and then raises req_full.
`timescale 1ns / 1ps

module modified_utf7_encoder #(
   parameter int QueueDepth = mue_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_is_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [6:0] rsp_out_char,
   output logic       rsp_last_of_run,
   output logic       rsp_end_of_string
);

   mue_pkg::bundle_type bundle, head;
   logic accept, q_empty, q_pop;

   assign accept = req_push && !req_full;

   mue_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .is_last (req_is_last),
      .bundle  (bundle)
   );

   mue_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (bundle),
      .full      (req_full),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty)
   );

   mue_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .head_valid    (!q_empty),
      .head_pop      (q_pop),
      .pop           (rsp_pop),
      .empty         (rsp_empty),
      .out_char      (rsp_out_char),
      .last_of_run   (rsp_last_of_run),
      .end_of_string (rsp_end_of_string)
   );

endmodule

// ===== design/mue_checker.sv =====
// Port-level checks for the modified UTF-7 encoder, bound to the top level.
`timescale 1ns / 1ps

module mue_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [6:0] rsp_out_char,
   input logic       rsp_last_of_run,
   input logic       rsp_end_of_string
);

   // nothing waits on the output right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("output not empty after reset");

   // every character shown is printable
   a_printable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_out_char >= 7'h20) && (rsp_out_char <= 7'h7E))
      else $error("non-printable character on output");

   // the end of the string is also the end of that byte's characters
   a_eos_lor: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_end_of_string) |-> rsp_last_of_run)
      else $error("end_of_string without last_of_run");

   // hold a stalled word
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_char)
         && $stable(rsp_last_of_run) && $stable(rsp_end_of_string)))
      else $error("stalled output word changed");

endmodule

bind modified_utf7_encoder mue_checker u_mue_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_out_char      (rsp_out_char),
   .rsp_last_of_run   (rsp_last_of_run),
   .rsp_end_of_string (rsp_end_of_string)
);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the modified UTF-7 encoder: directed, random, stall and drain tests.
`timescale 1ns / 1ps

module tb_top;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int TAIL_CYCLES = 20;
   localparam string SEXTET_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+,";

   typedef struct packed {
      logic [6:0] out_char;
      logic       last_of_run;
      logic       end_of_string;
   } char_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_is_last = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [6:0] rsp_out_char;
   logic       rsp_last_of_run;
   logic       rsp_end_of_string;

   // Predictor state
   logic [1:0] run_phase = mue_pkg::PHASE_PLAIN;
   logic [5:0] run_carry = 6'd0;
   logic [6:0] step_chars[$];
   char_word_type expected_chars[$];

   int  mismatch_count = 0;
   bit  idle_on = 1'b1;
   int  hold_request = 0;

   modified_utf7_encoder u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_in_byte       (req_in_byte),
      .req_is_last       (req_is_last),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_char      (rsp_out_char),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_string (rsp_end_of_string)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [6:0] b64_char(input logic [5:0] v);
      byte c;
      c = SEXTET_ALPHABET[v];
      return c[6:0];
   endfunction

   task automatic close_run_model();
      if (run_phase != mue_pkg::PHASE_PLAIN) begin
         if (run_phase != mue_pkg::PHASE_G0) step_chars.push_back(b64_char(run_carry));
         step_chars.push_back(mue_pkg::DASH_CHAR[6:0]);
         run_phase = mue_pkg::PHASE_PLAIN;
         run_carry = 6'd0;
      end
   endtask

   // Work out the characters one accepted byte produces and queue them
   task automatic predict_chars(input logic [7:0] b, input logic last);
      char_word_type w;
      step_chars.delete();
      if (b >= mue_pkg::PLAIN_LO && b <= mue_pkg::PLAIN_HI) begin
         close_run_model();
         step_chars.push_back(b[6:0]);
         if (b == mue_pkg::AMP_CHAR) step_chars.push_back(mue_pkg::DASH_CHAR[6:0]);
      end else begin
         if (run_phase == mue_pkg::PHASE_PLAIN) begin
            step_chars.push_back(mue_pkg::AMP_CHAR[6:0]);
            run_phase = mue_pkg::PHASE_G0;
            run_carry = 6'd0;
         end
         case (run_phase)
            mue_pkg::PHASE_G0: begin
               step_chars.push_back(b64_char(b[7:2]));
               run_carry = {b[1:0], 4'b0000};
               run_phase = mue_pkg::PHASE_G1;
            end
            mue_pkg::PHASE_G1: begin
               step_chars.push_back(b64_char(run_carry | {2'b00, b[7:4]}));
               run_carry = {b[3:0], 2'b00};
               run_phase = mue_pkg::PHASE_G2;
            end
            default: begin
               step_chars.push_back(b64_char(run_carry | {4'b0000, b[7:6]}));
               step_chars.push_back(b64_char(b[5:0]));
               run_carry = 6'd0;
               run_phase = mue_pkg::PHASE_G0;
            end
         endcase
      end
      if (last) close_run_model();
      for (int i = 0; i < step_chars.size(); i++) begin
         w.out_char      = step_chars[i];
         w.last_of_run   = (i == step_chars.size() - 1);
         w.end_of_string = last && (i == step_chars.size() - 1);
         expected_chars.push_back(w);
      end
   endtask

   // Offer one byte; keep push high afterwards so back-to-back words need no toggle
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = idle_on ? $urandom_range(0, 17) : 0;
      repeat (gap) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_in_byte <= b;
      req_is_last <= last;
      do @(posedge clock); while (req_full);
      predict_chars(b, last);
   endtask

   // Drop push so the last byte is not taken again, then wait for every result
   task automatic wait_drained();
      req_push <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_binary_byte();
      if ($urandom_range(0, 1)) return 8'($urandom_range(8'h00, 8'h1F));
      return 8'($urandom_range(8'h7F, 8'hFF));
   endfunction

   task automatic test_directed_edges();
      idle_on = 1'b1;
      send_byte(8'h41, 1'b0);
      send_byte(mue_pkg::AMP_CHAR, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h7E, 1'b0);
      // close a run with carried bits after one byte
      send_byte(8'h00, 1'b0);
      send_byte(8'h78, 1'b0);
      // close a run after two bytes
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(mue_pkg::DASH_CHAR, 1'b0);
      // full group, then close with no carry
      send_byte(8'h1F, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(mue_pkg::AMP_CHAR, 1'b0);
      // last byte in each run phase
      send_byte(8'h01, 1'b1);
      send_byte(8'h81, 1'b0);
      send_byte(8'h82, 1'b1);
      send_byte(8'h90, 1'b0);
      send_byte(8'h91, 1'b0);
      send_byte(8'h92, 1'b1);
      send_byte(mue_pkg::AMP_CHAR, 1'b1);
      send_byte(8'hFE, 1'b0);
      send_byte(8'h5A, 1'b1);
      send_byte(8'h7E, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_output_backpressure();
      idle_on = 1'b0;
      hold_request = HOLD_OFF_CYCLES;
      for (int k = 0; k < 20; k++) send_byte(8'($urandom_range(0, 255)), k == 19);
      idle_on = 1'b1;
   endtask

   task automatic test_drain_pause();
      for (int k = 0; k < 8; k++) send_byte(random_binary_byte(), k == 7);
      wait_drained();
      for (int k = 0; k < 8; k++) send_byte(8'($urandom_range(0, 255)), k == 7);
   endtask

   task automatic test_random_strings(input int n_items);
      int         sent;
      int         len;
      int         kind;
      logic [7:0] b;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 3) == 0) idle_on = !idle_on;
         len = $urandom_range(1, 12);
         for (int k = 0; k < len; k++) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) b = random_binary_byte();
            else if (kind == 5) b = mue_pkg::AMP_CHAR;
            else b = 8'($urandom_range(0, 255));
            send_byte(b, (k == len - 1) || ($urandom_range(0, 15) == 0));
            sent++;
         end
      end
      idle_on = 1'b1;
   endtask

   // Receiver: random stall before each word, plus a long hold-off on request
   initial begin : receiver
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            rsp_pop <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end
         stall = idle_on ? $urandom_range(0, 17) : 0;
         repeat (stall) begin
            rsp_pop <= 1'b0;
            @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   always @(posedge clock) begin
      char_word_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: char=%h last_of_run=%b end_of_string=%b",
                        rsp_out_char, rsp_last_of_run, rsp_end_of_string);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_out_char !== want.out_char || rsp_last_of_run !== want.last_of_run ||
                rsp_end_of_string !== want.end_of_string) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected char=%h lor=%b eos=%b, got char=%h lor=%b eos=%b",
                           want.out_char, want.last_of_run, want.end_of_string,
                           rsp_out_char, rsp_last_of_run, rsp_end_of_string);
            end
         end
      end
   end

   // Watchdog: end the run if no word moves for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : main
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_output_backpressure();
      test_drain_pause();
      test_random_strings(190);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
